### sv/cskd_pkg.sv
// Shared types, constants and functions of the C++ keyword detector.
package cskd_pkg;

  localparam int NumKw  = 7;
  localparam int NumHdr = 12;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIPWS = 2'd1,
    PH_NAME   = 2'd2,
    PH_CLOSED = 2'd3
  } phase_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic [7:0] ch;
    logic       char_valid;
    logic       line_end;
    logic       buffer_end;
  } item_t;

  // Keyword characters, indexed [keyword][position].
  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] p);
    logic [79:0] s;
    case (k)
      3'd0:    s = {"std::", 40'h0};
      3'd1:    s = {"public:", 24'h0};
      3'd2:    s = {"private:", 16'h0};
      3'd3:    s = "protected:";
      3'd4:    s = {"template", 16'h0};
      3'd5:    s = {"class", 40'h0};
      3'd6:    s = {"#include", 16'h0};
      default: s = '0;
    endcase
    kw_char = s[79 - 8 * p -: 8];
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0:    kw_len = 4'd5;
      3'd1:    kw_len = 4'd7;
      3'd2:    kw_len = 4'd8;
      3'd3:    kw_len = 4'd10;
      3'd4:    kw_len = 4'd8;
      3'd5:    kw_len = 4'd5;
      3'd6:    kw_len = 4'd8;
      default: kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] hdr_char(input logic [3:0] h, input logic [3:0] p);
    logic [103:0] s;
    case (h)
      4'd0:    s = {"cstdint", 48'h0};
      4'd1:    s = {"string", 56'h0};
      4'd2:    s = {"vector", 56'h0};
      4'd3:    s = {"map", 80'h0};
      4'd4:    s = {"list", 72'h0};
      4'd5:    s = {"array", 64'h0};
      4'd6:    s = {"bitset", 56'h0};
      4'd7:    s = {"queue", 64'h0};
      4'd8:    s = {"stack", 64'h0};
      4'd9:    s = {"forward", "_list", 8'h0};
      4'd10:   s = {"unordered", "_map"};
      4'd11:   s = {"unordered", "_set"};
      default: s = '0;
    endcase
    hdr_char = s[103 - 8 * p -: 8];
  endfunction

  function automatic logic [3:0] hdr_len(input logic [3:0] h);
    case (h)
      4'd0:    hdr_len = 4'd7;
      4'd1:    hdr_len = 4'd6;
      4'd2:    hdr_len = 4'd6;
      4'd3:    hdr_len = 4'd3;
      4'd4:    hdr_len = 4'd4;
      4'd5:    hdr_len = 4'd5;
      4'd6:    hdr_len = 4'd6;
      4'd7:    hdr_len = 4'd5;
      4'd8:    hdr_len = 4'd5;
      4'd9:    hdr_len = 4'd12;
      4'd10:   hdr_len = 4'd13;
      4'd11:   hdr_len = 4'd13;
      default: hdr_len = 4'd0;
    endcase
  endfunction

  // Longest keyword prefix that is a suffix of the matched prefix plus c.
  function automatic logic [3:0] kw_advance(input logic [2:0] k, input logic [3:0] p_in,
                                            input logic [7:0] c);
    logic [3:0] p;
    logic       ok;
    logic [3:0] res;
    p   = (p_in >= kw_len(k)) ? 4'd0 : p_in;
    res = 4'd0;
    for (int n = 1; n <= 10; n++) begin
      if (n <= int'(p) + 1 && kw_char(k, 4'(n - 1)) == c) begin
        ok = 1'b1;
        for (int j = 0; j < 9; j++) begin
          if (j < n - 1 && kw_char(k, 4'(j)) != kw_char(k, 4'(int'(p) - (n - 1) + j)))
            ok = 1'b0;
        end
        if (ok) res = 4'(n);
      end
    end
    kw_advance = res;
  endfunction

endpackage

### sv/cskd_queue.sv
// Two-entry queue between the front and back parts of the detector.
module cskd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  cskd_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output cskd_pkg::item_t rd_item
);
  cskd_pkg::item_t mem_r [cskd_pkg::QDepth];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'(cskd_pkg::QDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

### sv/cskd_front.sv
// Front part: unpacks and registers incoming transfers.
module cskd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_ch,
  input  logic [1:0]      in_flags,
  input  logic            in_last,
  output logic            q_valid,
  input  logic            q_ready,
  output cskd_pkg::item_t q_item
);
  logic            vld_r;
  cskd_pkg::item_t item_r;

  assign in_ready = !vld_r || q_ready;
  assign q_valid  = vld_r;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.ch         <= in_ch;
      item_r.char_valid <= in_flags[0];
      item_r.line_end   <= in_flags[1];
      item_r.buffer_end <= in_last;
    end
    if (!rst_n) vld_r <= 1'b0;
    else if (in_ready) vld_r <= in_valid;
  end
endmodule

### sv/cskd_back.sv
// Back part: keyword matchers, header-name matcher and sticky flag.
module cskd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  cskd_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_is_cpp
);
  logic [3:0]       prog_r  [cskd_pkg::NumKw];
  cskd_pkg::phase_t phase_r [cskd_pkg::NumKw];
  logic [11:0]      alive_r;
  logic [3:0]       off_r;
  logic             det_r;
  logic             ov_r, res_r;

  logic [3:0]       prog_nxt  [cskd_pkg::NumKw];
  cskd_pkg::phase_t phase_nxt [cskd_pkg::NumKw];
  logic [11:0]      alive_nxt;
  logic [3:0]       off_nxt;
  logic             det_nxt;
  logic             take;
  logic [7:0]       c;
  logic             ws, alpha;
  logic [3:0]       p;

  assign q_ready    = !ov_r || out_ready;
  assign take       = q_valid && q_ready;
  assign out_valid  = ov_r;
  assign out_is_cpp = res_r;
  assign c          = q_item.ch;
  assign ws         = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign alpha      = (c == "_") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");

  always_comb begin
    p         = 4'd0;
    alive_nxt = alive_r;
    off_nxt   = off_r;
    det_nxt   = det_r;
    for (int i = 0; i < cskd_pkg::NumKw; i++) begin
      prog_nxt[i]  = prog_r[i];
      phase_nxt[i] = phase_r[i];
    end
    if (q_item.char_valid) begin
      if (c == 8'd0) begin
        for (int i = 0; i < cskd_pkg::NumKw; i++) phase_nxt[i] = cskd_pkg::PH_CLOSED;
      end else begin
        for (int i = 0; i < cskd_pkg::NumKw; i++) begin
          case (phase_r[i])
            cskd_pkg::PH_SEARCH: begin
              p = cskd_pkg::kw_advance(3'(i), prog_r[i], c);
              if (p >= cskd_pkg::kw_len(3'(i))) begin
                prog_nxt[i] = 4'd0;
                if (i < 4) begin
                  det_nxt      = 1'b1;
                  phase_nxt[i] = cskd_pkg::PH_CLOSED;
                end else begin
                  phase_nxt[i] = cskd_pkg::PH_SKIPWS;
                end
              end else begin
                prog_nxt[i] = p;
              end
            end
            cskd_pkg::PH_SKIPWS: begin
              if (!ws) begin
                phase_nxt[i] = cskd_pkg::PH_CLOSED;
                if (i == 4 && c == "<") det_nxt = 1'b1;
                if (i == 5 && alpha) det_nxt = 1'b1;
                if (i == 6 && c == "<") begin
                  phase_nxt[i] = cskd_pkg::PH_NAME;
                  alive_nxt    = 12'hFFF;
                  off_nxt      = 4'd0;
                end
              end
            end
            cskd_pkg::PH_NAME: begin
              if (i == 6) begin
                for (int h = 0; h < cskd_pkg::NumHdr; h++) begin
                  if (alive_r[h]) begin
                    if (off_r >= cskd_pkg::hdr_len(4'(h)) ||
                        cskd_pkg::hdr_char(4'(h), off_r) != c)
                      alive_nxt[h] = 1'b0;
                    else if (off_r + 4'd1 == cskd_pkg::hdr_len(4'(h)))
                      det_nxt = 1'b1;
                  end
                end
                if (off_r != 4'd15) off_nxt = off_r + 4'd1;
                if (alive_nxt == 12'd0) phase_nxt[i] = cskd_pkg::PH_CLOSED;
              end
            end
            default: ;
          endcase
        end
      end
    end
    if (q_item.line_end || q_item.buffer_end) begin
      for (int i = 0; i < cskd_pkg::NumKw; i++) begin
        prog_nxt[i]  = 4'd0;
        phase_nxt[i] = cskd_pkg::PH_SEARCH;
      end
      alive_nxt = 12'd0;
      off_nxt   = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_item.buffer_end) res_r <= det_nxt;
    if (!rst_n) begin
      for (int i = 0; i < cskd_pkg::NumKw; i++) begin
        prog_r[i]  <= 4'd0;
        phase_r[i] <= cskd_pkg::PH_SEARCH;
      end
      alive_r <= 12'd0;
      off_r   <= 4'd0;
      det_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (take) begin
        for (int i = 0; i < cskd_pkg::NumKw; i++) begin
          prog_r[i]  <= prog_nxt[i];
          phase_r[i] <= phase_nxt[i];
        end
        alive_r <= alive_nxt;
        off_r   <= off_nxt;
        det_r   <= q_item.buffer_end ? 1'b0 : det_nxt;
      end
      if (q_ready) ov_r <= take && q_item.buffer_end;
    end
  end
endmodule

### sv/cpp_source_keyword_detector.sv
// Top level of the C++ keyword detector.
// The block takes one text byte per transfer and accepts a new transfer
// every cycle unless output stalls hold it. A front register stage takes
// the input, a two-entry queue decouples it from the back part, which
// runs all seven keyword matchers and the twelve header-name matchers on
// one byte per cycle while the output does not stall. A line matches on
// std::, public:, private:, protected:, on the first template followed by
// '<', the first class followed by a letter or underscore, or the first
// #include followed by '<' and a standard header name. The sticky result
// comes out as one transfer once in_tlast (buffer end) is taken; all state
// then clears for the next buffer. No clearing pass is needed after reset.
module cpp_source_keyword_detector (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // ch
  input  logic [1:0] in_tuser,   // [0] char_valid, [1] line_end
  input  logic       in_tlast,   // buffer_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_cpp, rest zero
);
  logic            f_valid, f_ready, b_valid, b_ready, is_cpp;
  cskd_pkg::item_t f_item, b_item;

  cskd_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_ch(in_tdata),
    .in_flags(in_tuser), .in_last(in_tlast),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  cskd_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  cskd_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_is_cpp(is_cpp)
  );

  assign out_tdata = {7'd0, is_cpp};
endmodule

### test/tb_top.sv
// Self-checking testbench for the C++ keyword detector: directed table plus random text buffers.
`timescale 1ns / 1ps
module tb_top;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 200;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // ch
  logic [1:0] in_tuser;    // [0] char_valid, [1] line_end
  logic       in_tlast;    // buffer_end
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [0] is_cpp, rest zero

  cpp_source_keyword_detector u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  typedef struct {
    logic [7:0] ch;
    logic       cv;
    logic       le;
    logic       be;
    int         want;   // typed-in result at buffer end, or -1
  } text_item_t;

  // One row of the directed table. An empty txt sends the single byte raw.
  typedef struct {
    string      txt;
    logic [7:0] raw;
    logic       cv;
    logic       le;
    logic       be;
    int         want;   // expected is_cpp when the row ends a buffer, or -1
  } dir_row_t;

  // Keyword and header tables kept locally so the predictor does not take them from the package.
  string kw_tab[7] = '{"std::", "public:", "private:", "protected:",
                       "template", "class", "#include"};
  string hdr_tab[12] = '{"cstdint", "string", "vector", "map", "list", "array",
                         "bitset", "queue", "stack", string'({"forward", "_list"}),
                         string'({"unordered", "_map"}), string'({"unordered", "_set"})};

  // Directed buffers: keywords but private:, the fall-back on overlapping
  // prefixes, zero byte, high bytes, bare markers, buffer end without line end.
  dir_row_t dir_tab[13] = '{
    '{"std::",        8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{"sstd::x",      8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{"protected:",   8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{"template <T>", 8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{"class _A",     8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{string'({"#include <unordered", "_set>"}), 8'h00, 1'b1, 1'b1, 1'b1, 1},
    '{"class 1",      8'h00, 1'b1, 1'b1, 1'b1, 0},
    '{"",             8'hFF, 1'b1, 1'b0, 1'b0, -1},
    '{"",             8'h00, 1'b1, 1'b0, 1'b0, -1},
    '{"std::",        8'h00, 1'b1, 1'b1, 1'b1, 0},
    '{"",             8'h80, 1'b0, 1'b0, 1'b1, 0},
    '{"",             8'h01, 1'b1, 1'b0, 1'b0, -1},
    '{"public:",      8'h00, 1'b1, 1'b0, 1'b0, -1}
  };

  // Predictor state.
  int               kw_prog[7];
  cskd_pkg::phase_t kw_phase[7];
  logic [11:0]      hdr_alive;
  int               hdr_off;
  logic             cpp_seen;

  logic       verdict_q[$];   // expected is_cpp per buffer
  int         want_q[$];      // typed-in expectation per buffer, -1 if none
  text_item_t text_q[$];      // items waiting to be driven
  int         errors;
  int         buffers_done;
  int         cycles;
  logic       hold_req = 1'b0;

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_ident_start(logic [7:0] c);
    return c == "_" || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  // Longest keyword prefix that is a suffix of the matched text plus c.
  function automatic int kw_step(int k, int p, logic [7:0] c);
    string s;
    bit    ok;
    s = kw_tab[k];
    if (p >= s.len()) p = 0;
    for (int n = p + 1; n >= 1; n--) begin
      if (s[n-1] != c) continue;
      ok = 1;
      for (int j = 0; j < n - 1; j++)
        if (s[j] != s[p - (n - 1) + j]) ok = 0;
      if (ok) return n;
    end
    return 0;
  endfunction

  function automatic void clear_line();
    foreach (kw_prog[i]) begin
      kw_prog[i] = 0;
      kw_phase[i] = cskd_pkg::PH_SEARCH;
    end
    hdr_alive = '0;
    hdr_off = 0;
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    int p;
    if (c == 8'h00) begin
      foreach (kw_phase[i]) kw_phase[i] = cskd_pkg::PH_CLOSED;
      return;
    end
    for (int i = 0; i < 7; i++) begin
      case (kw_phase[i])
        cskd_pkg::PH_SEARCH: begin
          p = kw_step(i, kw_prog[i], c);
          if (p >= kw_tab[i].len()) begin
            kw_prog[i] = 0;
            if (i < 4) begin
              cpp_seen = 1;
              kw_phase[i] = cskd_pkg::PH_CLOSED;
            end else begin
              kw_phase[i] = cskd_pkg::PH_SKIPWS;
            end
          end else begin
            kw_prog[i] = p;
          end
        end
        cskd_pkg::PH_SKIPWS: begin
          if (!is_space(c)) begin
            kw_phase[i] = cskd_pkg::PH_CLOSED;
            if (i == 4 && c == "<") cpp_seen = 1;
            if (i == 5 && is_ident_start(c)) cpp_seen = 1;
            if (i == 6 && c == "<") begin
              kw_phase[i] = cskd_pkg::PH_NAME;
              hdr_alive = 12'hFFF;
              hdr_off = 0;
            end
          end
        end
        cskd_pkg::PH_NAME: begin
          if (i == 6) begin
            for (int h = 0; h < 12; h++) begin
              if (!hdr_alive[h]) continue;
              if (hdr_off >= hdr_tab[h].len() || hdr_tab[h][hdr_off] != c)
                hdr_alive[h] = 0;
              else if (hdr_off + 1 == hdr_tab[h].len())
                cpp_seen = 1;
            end
            if (hdr_off < 15) hdr_off++;
            if (hdr_alive == '0) kw_phase[i] = cskd_pkg::PH_CLOSED;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // Runs one accepted item through the predictor.
  function automatic void predict_item(text_item_t it);
    if (it.cv) scan_byte(it.ch);
    if (it.le || it.be) clear_line();
    if (it.be) begin
      verdict_q.push_back(cpp_seen);
      want_q.push_back(it.want);
      cpp_seen = 0;
    end
  endfunction

  task automatic report_mismatch(string what, logic got, logic want);
    errors++;
    $display("MISMATCH at %0t: %s got %0b expected %0b", $time, what, got, want);
  endtask

  // Queues a text line; zero bytes are kept out, the last byte carries the markers.
  task automatic add_line(string s, bit end_line, bit end_buf, int want);
    text_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.ch = s[i];
      it.cv = 1;
      it.le = end_line && (i == s.len() - 1);
      it.be = end_buf && (i == s.len() - 1);
      it.want = want;
      text_q.push_back(it);
    end
  endtask

  task automatic add_item(logic [7:0] c, logic cv, logic le, logic be, int want);
    text_item_t it;
    it.ch = c; it.cv = cv; it.le = le; it.be = be; it.want = want;
    text_q.push_back(it);
  endtask

  // Random line: mostly near-miss C++ fragments glued with noise bytes.
  task automatic add_random_line(bit end_buf);
    string frags[22] = '{"std:", "std::", "sd::", "public:", "publi", "private :",
                         "protected:", "protecte", "template", "template <",
                         "templatetemplate<", "class", "class Foo", "class 9",
                         "#include", "#include <", "#include<vector>", "#include < map",
                         "unordered_s", string'({"forward", "_list"}), "bitset", "ststd::"};
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0: s = {s, " "};
        1: s = {s, string'(8'($urandom_range(1, 255)))};
        default: s = {s, frags[$urandom_range(0, 21)]};
      endcase
    end
    // The high bytes and zero byte paths are also hit by occasional raw items.
    if ($urandom_range(0, 9) == 0) add_item(8'h00, 1, 0, 0, -1);
    if ($urandom_range(0, 7) == 0) add_item(8'($urandom), 0, 0, 0, -1);
    if ($urandom_range(0, 5) == 0) begin
      add_line(s, 1, 0, -1);
      add_item(8'($urandom), 0, 1, end_buf, -1);
    end else begin
      add_line(s, 1, end_buf, -1);
    end
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("cpp_source_keyword_detector test failed");
      $finish;
    end
  end

  // Result checker: every accepted result is matched with the oldest verdict.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("MISMATCH at %0t: result with nothing expected", $time);
      end else begin
        logic want;
        int   typed;
        want = verdict_q.pop_front();
        typed = want_q.pop_front();
        if (out_tdata[0] !== want) report_mismatch("is_cpp", out_tdata[0], want);
        if (typed >= 0 && out_tdata[0] !== typed[0])
          report_mismatch("is_cpp against table", out_tdata[0], typed[0]);
        if (out_tdata[7:1] !== '0) report_mismatch("pad bits", |out_tdata[7:1], 1'b0);
        buffers_done++;
      end
    end
  end

  // Receiver: own stall pattern, plus one long hold-off counted here while
  // the sender keeps offering.
  initial begin
    int phase_cnt;
    int hold_cnt;
    bit hold_done;
    out_tready = 0;
    phase_cnt = 0;
    hold_cnt = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_cnt = HoldCycles;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 0;
      end else if (phase_cnt % 64 < 20) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    text_item_t it;
    int burst;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 0;
    cpp_seen = 0;
    clear_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].txt.len() == 0)
        add_item(dir_tab[r].raw, dir_tab[r].cv, dir_tab[r].le, dir_tab[r].be,
                 dir_tab[r].want);
      else
        add_line(dir_tab[r].txt, dir_tab[r].le, dir_tab[r].be, dir_tab[r].want);
    end
    // Bare buffer end closing the last table line, which had no line end.
    add_item(8'h00, 0, 0, 1, 1);

    while (text_q.size() < 720) begin
      int lines;
      lines = $urandom_range(1, 4);
      for (int l = 0; l < lines; l++) add_random_line(l == lines - 1);
    end

    while (text_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && text_q.size() > 0; b++) begin
        it = text_q.pop_front();
        @(negedge clk);
        in_tvalid <= 1;
        in_tdata <= it.ch;
        in_tuser <= {it.le, it.cv};
        in_tlast <= it.be;
        do @(posedge clk); while (!in_tready);
        predict_item(it);
        // Ask the receiver for its long hold-off once, mid run.
        if (text_q.size() == 500) hold_req = 1;
      end
      @(negedge clk);
      in_tvalid <= 0;
      repeat ($urandom_range(0, 5)) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 0;

    while (verdict_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d buffers of text with keyword fragments, zero bytes and markers,",
             buffers_done);
    $display("under bursty input, random output stalls and one long output hold-off.");
    if (errors == 0) begin
      $display("cpp_source_keyword_detector test passed");
    end else begin
      $display("cpp_source_keyword_detector test failed");
    end
    $finish;
  end
endmodule
